// ----- rtl/rssa_pkg.sv -----
// Package: shared types, constants and codes for the ramp-and-soak aligner.
package rssa_pkg;
  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int BAND = 40;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_ALIGN  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_DIV,
    ST_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [26:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [26:0] quotient;
  } div_rsp_t;
endpackage

// ----- rtl/rssa_if.sv -----
// Interfaces: valid/ready channels for input and result beats.
interface rssa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic signed [15:0] segment_target;
  logic [15:0] segment_rate;
  logic [15:0] segment_soak;
  logic signed [15:0] measured_temp;
  logic signed [15:0] start_temp;
  modport source(output valid, operation, segment_target, segment_rate, segment_soak,
                 measured_temp, start_temp, input ready);
  modport sink(input valid, operation, segment_target, segment_rate, segment_soak,
               measured_temp, start_temp, output ready);
endinterface

interface rssa_out_if;
  logic        valid;
  logic        ready;
  logic        aligned_ok;
  logic [4:0]  segment_position;
  logic signed [15:0] aligned_setpoint;
  logic [31:0] elapsed_minutes;
  logic        start_mode;
  modport source(output valid, aligned_ok, segment_position, aligned_setpoint,
                 elapsed_minutes, start_mode, input ready);
  modport sink(input valid, aligned_ok, segment_position, aligned_setpoint,
               elapsed_minutes, start_mode, output ready);
endinterface

// ----- rtl/rssa_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module rssa_div (
  input  logic                clk,
  input  logic                rst_n,
  input  rssa_pkg::div_req_t  req,
  output rssa_pkg::div_rsp_t  rsp
);
  import rssa_pkg::*;
  localparam int W = 27;

  logic [W-1:0] quo_r, quo_nxt;
  logic [15:0]  rem_r, rem_nxt;
  logic [15:0]  dvs_r, dvs_nxt;
  logic [4:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [16:0]  trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[W-1]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 5'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 16'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule

// ----- rtl/ramp_soak_schedule_aligner.sv -----
// Top level: ramp-and-soak schedule store and segment walker.
// Clear and append beats complete in ST_IDLE. An align beat walks the stored
// segments one at a time; each segment passes through a table read state
// (ST_FETCH), an evaluation state (ST_EVAL) and, when its rate is nonzero
// and the leg is not flat, a wait in the bit-serial divider for a 27-bit
// quotient (ST_DIV), then an accumulate state (ST_NEXT). The result is valid
// in the cycle after the last segment visited. It sits in an output register
// until taken; input is not ready during an align or while a result waits.
module ramp_soak_schedule_aligner #(
  parameter int MAX_SEGMENTS = rssa_pkg::MAX_SEGMENTS_DEF
) (
  input logic clk,
  input logic rst_n,
  rssa_in_if.sink    in_ch,
  rssa_out_if.source out_ch
);
  import rssa_pkg::*;
  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  logic [15:0] tgt_mem [MAX_SEGMENTS];
  logic [15:0] rate_mem [MAX_SEGMENTS];
  logic [15:0] soak_mem [MAX_SEGMENTS];

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic signed [17:0] from_r, from_nxt;
  logic signed [17:0] meas_r, meas_nxt;
  logic [32:0] accum_r, accum_nxt;
  logic past_r, past_nxt;
  logic cool_r, cool_nxt;
  logic ramp_r, ramp_nxt;
  logic signed [17:0] sp_r, sp_nxt;
  logic [15:0] rd_tgt_r, rd_rate_r, rd_soak_r;
  logic ov_r, ov_nxt;
  logic ov_ok_r, ov_ok_nxt;
  logic [4:0] ov_pos_r, ov_pos_nxt;
  logic [15:0] ov_sp_r, ov_sp_nxt;
  logic [31:0] ov_el_r, ov_el_nxt;
  logic ov_mode_r, ov_mode_nxt;

  div_req_t dreq;
  div_rsp_t drsp;

  rssa_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic in_fire, wr_en;
  logic signed [17:0] to_s, d_s, p_s;
  logic [16:0] mag;
  logic heat, cool;
  logic [32:0] sum1, sum2;

  assign in_ch.ready = (state_r == ST_IDLE) && !ov_r;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign wr_en = in_fire && (op_t'(in_ch.operation) == OP_APPEND) &&
                 (count_r < CW'(MAX_SEGMENTS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tgt_mem[count_r[IW-1:0]]  <= in_ch.segment_target;
      rate_mem[count_r[IW-1:0]] <= in_ch.segment_rate;
      soak_mem[count_r[IW-1:0]] <= in_ch.segment_soak;
    end
    rd_tgt_r  <= tgt_mem[idx_r[IW-1:0]];
    rd_rate_r <= rate_mem[idx_r[IW-1:0]];
    rd_soak_r <= soak_mem[idx_r[IW-1:0]];
  end

  always_comb begin
    to_s = 18'(signed'(rd_tgt_r));
    d_s  = to_s - from_r;
    heat = (d_s >= 18'sd1);
    cool = (d_s <= -18'sd1);
    mag  = d_s[17] ? 17'(-d_s) : 17'(d_s);
    p_s  = heat ? (meas_r - from_r) : (from_r - meas_r);
    if (p_s < 0) p_s = '0;
    if (p_s > signed'({1'b0, mag})) p_s = signed'({1'b0, mag});
    sum1 = accum_r + 33'(drsp.quotient);
    if (sum1 > 33'hFFFFFFFF) sum1 = 33'hFFFFFFFF;
    sum2 = (past_r ? sum1 : accum_r) + 33'({rd_soak_r, 4'b0});
    if (sum2 > 33'hFFFFFFFF) sum2 = 33'hFFFFFFFF;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    from_nxt = from_r;
    meas_nxt = meas_r;
    accum_nxt = accum_r;
    past_nxt = past_r;
    cool_nxt = cool_r;
    ramp_nxt = ramp_r;
    sp_nxt = sp_r;
    ov_nxt = ov_r;
    ov_ok_nxt = ov_ok_r;
    ov_pos_nxt = ov_pos_r;
    ov_sp_nxt = ov_sp_r;
    ov_el_nxt = ov_el_r;
    ov_mode_nxt = ov_mode_r;
    dreq = '0;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (op_t'(in_ch.operation))
            OP_CLEAR: count_nxt = '0;
            OP_APPEND: if (wr_en) count_nxt = count_r + CW'(1);
            OP_ALIGN: begin
              if (count_r == '0) begin
                ov_nxt = 1'b1; ov_ok_nxt = 1'b0; ov_pos_nxt = '0;
                ov_sp_nxt = '0; ov_el_nxt = '0; ov_mode_nxt = 1'b0;
              end else begin
                idx_nxt = '0;
                from_nxt = 18'(in_ch.start_temp);
                meas_nxt = 18'(in_ch.measured_temp);
                accum_nxt = '0;
                state_nxt = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: state_nxt = ST_EVAL;
      ST_EVAL: begin
        cool_nxt = cool;
        ramp_nxt = (heat || cool) && (rd_rate_r != 16'd0);
        if (heat) past_nxt = meas_r > to_s + 18'sd40;
        else if (cool) past_nxt = meas_r < to_s - 18'sd40;
        else past_nxt = (meas_r - to_s > 18'sd40) || (to_s - meas_r > 18'sd40);
        sp_nxt = from_r;
        if (ramp_nxt && !past_nxt) sp_nxt = heat ? from_r + p_s : from_r - p_s;
        if (ramp_nxt) begin
          dreq.start = 1'b1;
          // divide (distance * 960) by rate; past uses full leg
          dreq.dividend = 27'((past_nxt ? {1'b0, mag} : 17'(p_s)) * 27'd960);
          dreq.divisor = rd_rate_r;
          state_nxt = ST_DIV;
        end else state_nxt = ST_NEXT;
      end
      ST_DIV: if (drsp.done) state_nxt = ST_NEXT;
      ST_NEXT: begin
        if (past_r) begin
          accum_nxt = ramp_r ? sum2 : (accum_r + 33'({rd_soak_r, 4'b0}) > 33'hFFFFFFFF ?
                      33'hFFFFFFFF : accum_r + 33'({rd_soak_r, 4'b0}));
          from_nxt = to_s;
          idx_nxt = idx_r + CW'(1);
          if (idx_r + CW'(1) >= count_r) begin
            ov_nxt = 1'b1; ov_ok_nxt = 1'b1; ov_pos_nxt = 5'(count_r);
            ov_sp_nxt = rd_tgt_r; ov_el_nxt = accum_nxt[31:0]; ov_mode_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else state_nxt = ST_FETCH;
        end else begin
          ov_nxt = 1'b1; ov_ok_nxt = 1'b1; ov_pos_nxt = 5'(idx_r);
          ov_sp_nxt = sp_r[15:0];
          ov_el_nxt = ramp_r ? sum1[31:0] : accum_r[31:0];
          ov_mode_nxt = cool_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r <= ov_nxt;
    end
    idx_r <= idx_nxt;
    from_r <= from_nxt;
    meas_r <= meas_nxt;
    accum_r <= accum_nxt;
    past_r <= past_nxt;
    cool_r <= cool_nxt;
    ramp_r <= ramp_nxt;
    sp_r <= sp_nxt;
    ov_ok_r <= ov_ok_nxt;
    ov_pos_r <= ov_pos_nxt;
    ov_sp_r <= ov_sp_nxt;
    ov_el_r <= ov_el_nxt;
    ov_mode_r <= ov_mode_nxt;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.aligned_ok = ov_ok_r;
  assign out_ch.segment_position = ov_pos_r;
  assign out_ch.aligned_setpoint = ov_sp_r;
  assign out_ch.elapsed_minutes = ov_el_r;
  assign out_ch.start_mode = ov_mode_r;
endmodule

// ----- rtl/rssa_checker.sv -----
// Checker: port-level properties of the aligner, bound to the top level.
module rssa_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_ok,
  input logic [4:0] out_pos,
  input logic [15:0] out_sp,
  input logic out_mode
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sp) && $stable(out_pos))
    else $error("result beat changed while stalled");
  a_noready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while a result waits");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_pos == 5'd0 && out_sp == 16'd0 && !out_mode)
    else $error("empty result carries nonzero fields");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind ramp_soak_schedule_aligner rssa_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_ok(out_ch.aligned_ok),
  .out_pos(out_ch.segment_position), .out_sp(out_ch.aligned_setpoint),
  .out_mode(out_ch.start_mode)
);
